// ----- design/cone_pair_bounds_test_macros.svh -----
// Assertion macros for the checker file of the cone pair bounds test.
// The clock is clk and the active-low reset is rst_n in every user.
`ifndef CONE_PAIR_BOUNDS_TEST_MACROS_SVH
`define CONE_PAIR_BOUNDS_TEST_MACROS_SVH

// Checked only while out of reset.
`define CPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/cpb_pkg.sv -----
// Package of the cone pair bounds test: vector types, widths, register
// indexes, region codes and the cross product function. No dependencies.
`default_nettype none

package cpb_pkg;

  localparam int CPB_FRAC_BITS = 14;
  localparam int COMP_W  = 16;
  localparam int PROD_W  = 2 * COMP_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int XC_W    = PROD_W + 1;
  localparam int TPROD_W = COMP_W + XC_W;
  localparam int TRI_W   = TPROD_W + 2;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;

  typedef struct packed {
    logic signed [COMP_W-1:0] z;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [XC_W-1:0] z;
    logic signed [XC_W-1:0] y;
    logic signed [XC_W-1:0] x;
  } xvec_t;

  typedef struct packed {
    vec_t                     a;
    logic signed [COMP_W-1:0] a_cos;
    vec_t                     b;
    logic signed [COMP_W-1:0] b_cos;
    vec_t                     t1;
    vec_t                     t2;
    logic signed [COMP_W-1:0] t_cos;
    logic                     two_cones;
  } cfg_t;

  typedef struct packed {
    xvec_t ab;
    xvec_t at1;
    xvec_t t1b;
    xvec_t t2a;
    xvec_t bt2;
  } cross_t;

  typedef enum logic [2:0] {
    REG_A_AXIS   = 3'd0,
    REG_A_COS    = 3'd1,
    REG_B_AXIS   = 3'd2,
    REG_B_COS    = 3'd3,
    REG_T1_CTR   = 3'd4,
    REG_T2_CTR   = 3'd5,
    REG_T_COS    = 3'd6,
    REG_TWO_CONE = 3'd7
  } reg_idx_t;

  localparam logic [2:0] REGION_CONE_A   = 3'd0;
  localparam logic [2:0] REGION_CONE_B   = 3'd1;
  localparam logic [2:0] REGION_LONE     = 3'd2;
  localparam logic [2:0] REGION_TANGENT  = 3'd3;
  localparam logic [2:0] REGION_SIDE_ONE = 3'd4;
  localparam logic [2:0] REGION_SIDE_TWO = 3'd5;

  function automatic xvec_t cross3(vec_t u, vec_t v);
    xvec_t r;
    r.x = XC_W'(u.y * v.z) - XC_W'(u.z * v.y);
    r.y = XC_W'(u.z * v.x) - XC_W'(u.x * v.z);
    r.z = XC_W'(u.x * v.y) - XC_W'(u.y * v.x);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/cpb_regs.sv -----
// Configuration register file on an APB-style port for the cone pair
// bounds test. Depends on cpb_pkg.
`default_nettype none

module cpb_regs import cpb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_A_AXIS:   cfg_r.a         <= vec_t'(pwdata[3*COMP_W-1:0]);
        REG_A_COS:    cfg_r.a_cos     <= pwdata[COMP_W-1:0];
        REG_B_AXIS:   cfg_r.b         <= vec_t'(pwdata[3*COMP_W-1:0]);
        REG_B_COS:    cfg_r.b_cos     <= pwdata[COMP_W-1:0];
        REG_T1_CTR:   cfg_r.t1        <= vec_t'(pwdata[3*COMP_W-1:0]);
        REG_T2_CTR:   cfg_r.t2        <= vec_t'(pwdata[3*COMP_W-1:0]);
        REG_T_COS:    cfg_r.t_cos     <= pwdata[COMP_W-1:0];
        REG_TWO_CONE: cfg_r.two_cones <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_A_AXIS:   prdata = {16'b0, cfg_r.a};
      REG_A_COS:    prdata = {48'b0, cfg_r.a_cos};
      REG_B_AXIS:   prdata = {16'b0, cfg_r.b};
      REG_B_COS:    prdata = {48'b0, cfg_r.b_cos};
      REG_T1_CTR:   prdata = {16'b0, cfg_r.t1};
      REG_T2_CTR:   prdata = {16'b0, cfg_r.t2};
      REG_T_COS:    prdata = {48'b0, cfg_r.t_cos};
      REG_TWO_CONE: prdata = {63'b0, cfg_r.two_cones};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/cpb_cross.sv -----
// Registered cross products of the configured axes and tangent centers,
// used as plane normals by the datapath. Depends on cpb_pkg.
`default_nettype none

module cpb_cross import cpb_pkg::*; (
  input  wire logic   clk,
  input  wire cfg_t   cfg,
  output      cross_t xp
);

  cross_t xp_r;

  always_ff @(posedge clk) begin
    xp_r.ab  <= cross3(cfg.a, cfg.b);
    xp_r.at1 <= cross3(cfg.a, cfg.t1);
    xp_r.t1b <= cross3(cfg.t1, cfg.b);
    xp_r.t2a <= cross3(cfg.t2, cfg.a);
    xp_r.bt2 <= cross3(cfg.b, cfg.t2);
  end

  assign xp = xp_r;

endmodule

`default_nettype wire

// ----- design/cpb_pipe.sv -----
// Four-stage datapath of the cone pair bounds test: input, products, sums,
// decision. Each stage holds its own valid bit. Depends on cpb_pkg.
`default_nettype none

module cpb_pipe import cpb_pkg::*; #(
  parameter int FRAC_BITS = CPB_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire cross_t            xp,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [COMP_W-1:0] in_dir_x,
  input  wire logic [COMP_W-1:0] in_dir_y,
  input  wire logic [COMP_W-1:0] in_dir_z,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              out_allowed,
  output      logic [2:0]        out_deciding_region
);

  localparam int NDOT  = 4;
  localparam int NTRI  = 5;
  localparam int CMP_W = (COMP_W + FRAC_BITS + 1 > DOT_W + 1) ?
                         COMP_W + FRAC_BITS + 1 : DOT_W + 1;

  logic run_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  vec_t                     d_r;
  logic signed [PROD_W-1:0] pd_r [NDOT][3];
  logic signed [TPROD_W-1:0] pt_r [NTRI][3];
  logic signed [DOT_W-1:0]  sd_r [NDOT];
  logic signed [TRI_W-1:0]  st_r [NTRI];
  logic                     ok_r;
  logic [2:0]               region_r;

  vec_t  dv [NDOT];
  xvec_t xv [NTRI];

  logic signed [CMP_W-1:0] sc_a, sc_b, sc_t;
  logic signed [CMP_W-1:0] dot_a, dot_b, dot_t1, dot_t2;
  logic                    pos_at1, pos_t1b, pos_t2a, pos_bt2;
  logic                    ok_nxt;
  logic [2:0]              region_nxt;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = run_r && rdy1;

  assign dv[0] = cfg.a;
  assign dv[1] = cfg.b;
  assign dv[2] = cfg.t1;
  assign dv[3] = cfg.t2;
  assign xv[0] = xp.ab;
  assign xv[1] = xp.at1;
  assign xv[2] = xp.t1b;
  assign xv[3] = xp.t2a;
  assign xv[4] = xp.bt2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      run_r <= 1'b1;
      if (rdy1) begin
        v1_r <= in_valid && run_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r.x <= in_dir_x;
      d_r.y <= in_dir_y;
      d_r.z <= in_dir_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int i = 0; i < NDOT; i++) begin
        pd_r[i][0] <= dv[i].x * d_r.x;
        pd_r[i][1] <= dv[i].y * d_r.y;
        pd_r[i][2] <= dv[i].z * d_r.z;
      end
      for (int i = 0; i < NTRI; i++) begin
        pt_r[i][0] <= xv[i].x * d_r.x;
        pt_r[i][1] <= xv[i].y * d_r.y;
        pt_r[i][2] <= xv[i].z * d_r.z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      for (int i = 0; i < NDOT; i++) begin
        sd_r[i] <= DOT_W'(pd_r[i][0]) + DOT_W'(pd_r[i][1]) + DOT_W'(pd_r[i][2]);
      end
      for (int i = 0; i < NTRI; i++) begin
        st_r[i] <= TRI_W'(pt_r[i][0]) + TRI_W'(pt_r[i][1]) + TRI_W'(pt_r[i][2]);
      end
    end
  end

  always_comb begin
    sc_a    = CMP_W'(cfg.a_cos) <<< FRAC_BITS;
    sc_b    = CMP_W'(cfg.b_cos) <<< FRAC_BITS;
    sc_t    = CMP_W'(cfg.t_cos) <<< FRAC_BITS;
    dot_a   = CMP_W'(sd_r[0]);
    dot_b   = CMP_W'(sd_r[1]);
    dot_t1  = CMP_W'(sd_r[2]);
    dot_t2  = CMP_W'(sd_r[3]);
    pos_at1 = !st_r[1][TRI_W-1] && (st_r[1] != '0);
    pos_t1b = !st_r[2][TRI_W-1] && (st_r[2] != '0);
    pos_t2a = !st_r[3][TRI_W-1] && (st_r[3] != '0);
    pos_bt2 = !st_r[4][TRI_W-1] && (st_r[4] != '0);
    if (dot_a >= sc_a) begin
      ok_nxt     = 1'b1;
      region_nxt = REGION_CONE_A;
    end else if (!cfg.two_cones) begin
      ok_nxt     = 1'b0;
      region_nxt = REGION_LONE;
    end else if (dot_b >= sc_b) begin
      ok_nxt     = 1'b1;
      region_nxt = REGION_CONE_B;
    end else if (dot_t1 > sc_t || dot_t2 > sc_t) begin
      ok_nxt     = 1'b0;
      region_nxt = REGION_TANGENT;
    end else if (st_r[0][TRI_W-1]) begin
      ok_nxt     = pos_at1 && pos_t1b;
      region_nxt = REGION_SIDE_ONE;
    end else begin
      ok_nxt     = pos_t2a && pos_bt2;
      region_nxt = REGION_SIDE_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      ok_r     <= ok_nxt;
      region_r <= region_nxt;
    end
  end

  assign out_valid           = v4_r;
  assign out_allowed         = ok_r;
  assign out_deciding_region = region_r;

endmodule

`default_nettype wire

// ----- design/cone_pair_bounds_test.sv -----
// A result passes the input, product, sum and decision registers before it is shown.
// Throughput: one item per cycle while out_ready stays high, through the four-stage pipeline.
// Each stage stalls on its own, so bubbles are filled while the output waits.
// Reset (synchronous, rst_n low) clears the configuration registers and the valid
// bits, which empties the pipeline; in_ready rises in the cycle after reset is released.
`default_nettype none

module cone_pair_bounds_test import cpb_pkg::*; #(
  parameter int FRAC_BITS = CPB_FRAC_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [15:0]       in_dir_x,
  input  wire logic [15:0]       in_dir_y,
  input  wire logic [15:0]       in_dir_z,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic              out_allowed,
  output      logic [2:0]        out_deciding_region,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready
);

  cfg_t   cfg;
  cross_t xp;

  cpb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpb_cross u_cross (
    .clk (clk),
    .cfg (cfg),
    .xp  (xp)
  );

  cpb_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pipe (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .xp                  (xp),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_dir_x            (in_dir_x),
    .in_dir_y            (in_dir_y),
    .in_dir_z            (in_dir_z),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_allowed         (out_allowed),
    .out_deciding_region (out_deciding_region)
  );

endmodule

`default_nettype wire

// ----- design/cpb_checker.sv -----
// Port-level checker of the cone pair bounds test, bound to the top level.
// Depends on cpb_pkg and cone_pair_bounds_test_macros.svh.
`default_nettype none

`include "cone_pair_bounds_test_macros.svh"

module cpb_checker import cpb_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_allowed,
  input wire logic [2:0] out_deciding_region
);

  logic       region_allows;
  logic       stalled;
  logic [3:0] result_bits;

  assign region_allows = (out_deciding_region == REGION_CONE_A) ||
                         (out_deciding_region == REGION_CONE_B) ||
                         (out_deciding_region == REGION_SIDE_ONE) ||
                         (out_deciding_region == REGION_SIDE_TWO);
  assign stalled       = out_valid && !out_ready;
  assign result_bits   = {out_allowed, out_deciding_region};

  `CPB_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> !out_valid, "Result shown after reset")

  `CPB_ASSERT(a_allowed_region, out_valid && out_allowed |-> region_allows, "Bad allowed region")

  `CPB_ASSERT(a_ready_when_empty, $past(rst_n) && !out_valid |-> in_ready, "Input blocked while empty")

  `CPB_ASSERT(a_out_hold, stalled |=> out_valid && $stable(result_bits), "Stalled result changed")

endmodule

bind cone_pair_bounds_test cpb_checker u_cpb_checker (.*);

`default_nettype wire
